### rtl/jnl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jnl_pkg;

    localparam int unsigned MAX_LEN = 64;
    localparam int unsigned LEN_W   = 7;
    localparam int unsigned MAG_W   = 63;
    localparam int unsigned VAL_W   = 64;

    localparam logic [1:0] ST_INT    = 2'd0;
    localparam logic [1:0] ST_REAL   = 2'd1;
    localparam logic [1:0] ST_SYNTAX = 2'd2;
    localparam logic [1:0] ST_OVER   = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UPE   = 8'h45;
    localparam logic [7:0] CH_LOWE  = 8'h65;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       buffer_end;
    } t_in;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] int_value;
        logic [LEN_W-1:0]        num_length;
    } t_out;

endpackage

`default_nettype wire

### rtl/jnl_lexer.sv
`timescale 1ns / 1ps
`default_nettype none

module jnl_lexer (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_take,
    input  wire jnl_pkg::t_in i_item,
    output logic              o_res_valid,
    output jnl_pkg::t_out     o_res
);

    typedef enum logic [3:0] {
        S_INIT  = 4'd0,
        S_ZERO  = 4'd1,
        S_SIGN  = 4'd2,
        S_INT   = 4'd3,
        S_DOT   = 4'd4,
        S_FRAC  = 4'd5,
        S_EXP   = 4'd6,
        S_ESIGN = 4'd7,
        S_EDIG  = 4'd8,
        S_SKIP  = 4'd9
    } t_state;

    t_state                          r_state, st, n_state;
    logic [jnl_pkg::MAG_W-1:0]       r_mag, n_mag;
    logic signed [jnl_pkg::VAL_W-1:0] r_nmag, n_nmag;
    logic                            r_neg, n_neg;
    logic [jnl_pkg::LEN_W-1:0]       r_count, n_count, cnt_inc, len;

    logic [7:0] c;
    logic       last, is_digit, is_term, is_e, accum;
    logic       has_res;
    logic [1:0] res;
    logic [3:0] d;
    logic [jnl_pkg::MAG_W+3:0]       mag_x10;
    logic signed [jnl_pkg::VAL_W-1:0] nmag_x10;
    logic       ovf;

    assign c        = i_item.char_byte;
    assign last     = i_item.buffer_end;
    assign is_digit = (c >= jnl_pkg::CH_ZERO) && (c <= jnl_pkg::CH_NINE);
    assign is_e     = (c == jnl_pkg::CH_UPE) || (c == jnl_pkg::CH_LOWE);
    assign is_term  = (c == jnl_pkg::CH_SPACE) || (c == jnl_pkg::CH_TAB) ||
                      (c == jnl_pkg::CH_LF) || (c == jnl_pkg::CH_CR) ||
                      (c == jnl_pkg::CH_COMMA) || (c == jnl_pkg::CH_RBRACE) ||
                      (c == jnl_pkg::CH_RBRACKET);
    assign d        = c[3:0];

    // Times ten plus digit, kept wide so that any carry past 63 bits shows overflow.
    assign mag_x10  = {1'b0, r_mag, 3'b000} + {3'b000, r_mag, 1'b0} +
                      {{jnl_pkg::MAG_W{1'b0}}, d};
    assign ovf      = |mag_x10[jnl_pkg::MAG_W+3:jnl_pkg::MAG_W];
    // The negated value is tracked alongside so the output needs no extra negation.
    assign nmag_x10 = (r_nmag <<< 3) + (r_nmag <<< 1) -
                      $signed({{(jnl_pkg::VAL_W-4){1'b0}}, d});
    assign cnt_inc  = r_count + 1'b1;

    always_comb begin
        st      = r_state;
        has_res = 1'b0;
        res     = jnl_pkg::ST_SYNTAX;
        len     = '0;
        accum   = 1'b0;
        n_neg   = r_neg;
        unique case (r_state)
            S_INIT, S_SIGN: begin
                if (is_digit && (c != jnl_pkg::CH_ZERO)) begin
                    accum = 1'b1;
                    st    = S_INT;
                end else if (c == jnl_pkg::CH_ZERO) begin
                    st = S_ZERO;
                end else if ((c == jnl_pkg::CH_MINUS) && (r_state == S_INIT)) begin
                    n_neg = 1'b1;
                    st    = S_SIGN;
                end else begin
                    has_res = 1'b1;
                end
            end
            S_ZERO, S_INT: begin
                if (is_digit && (r_state == S_INT)) begin
                    if (ovf) begin
                        has_res = 1'b1;
                        res     = jnl_pkg::ST_OVER;
                    end else begin
                        accum = 1'b1;
                    end
                end else if (c == jnl_pkg::CH_DOT) begin
                    st = S_DOT;
                end else if (is_e) begin
                    st = S_EXP;
                end else if (is_term) begin
                    has_res = 1'b1;
                    res     = jnl_pkg::ST_INT;
                    len     = r_count;
                end else begin
                    has_res = 1'b1;
                end
            end
            S_DOT, S_ESIGN: begin
                if (is_digit) begin
                    st = (r_state == S_DOT) ? S_FRAC : S_EDIG;
                end else begin
                    has_res = 1'b1;
                end
            end
            S_FRAC, S_EDIG: begin
                if (is_digit) begin
                    st = r_state;
                end else if (is_e && (r_state == S_FRAC)) begin
                    st = S_EXP;
                end else if (is_term) begin
                    has_res = 1'b1;
                    res     = jnl_pkg::ST_REAL;
                    len     = r_count;
                end else begin
                    has_res = 1'b1;
                end
            end
            S_EXP: begin
                if ((c == jnl_pkg::CH_PLUS) || (c == jnl_pkg::CH_MINUS)) begin
                    st = S_ESIGN;
                end else if (is_digit) begin
                    st = S_EDIG;
                end else begin
                    has_res = 1'b1;
                end
            end
            S_SKIP: begin
                st = S_SKIP;
            end
            default: begin
                has_res = 1'b1;
            end
        endcase

        if ((r_state != S_SKIP) && !has_res) begin
            if (last) begin
                has_res = 1'b1;
                len     = cnt_inc;
                if ((st == S_ZERO) || (st == S_INT)) begin
                    res = jnl_pkg::ST_INT;
                end else if ((st == S_FRAC) || (st == S_EDIG)) begin
                    res = jnl_pkg::ST_REAL;
                end else begin
                    res = jnl_pkg::ST_SYNTAX;
                end
            end else if (cnt_inc >= jnl_pkg::LEN_W'(jnl_pkg::MAX_LEN)) begin
                has_res = 1'b1;
                res     = jnl_pkg::ST_OVER;
            end
        end

        n_mag  = accum ? mag_x10[jnl_pkg::MAG_W-1:0] : r_mag;
        n_nmag = accum ? nmag_x10 : r_nmag;

        if (r_state == S_SKIP) begin
            n_state = last ? S_INIT : S_SKIP;
            n_count = r_count;
            if (last) begin
                n_mag  = '0;
                n_nmag = '0;
                n_neg  = 1'b0;
                n_count = '0;
            end
        end else if (has_res) begin
            n_state = last ? S_INIT : S_SKIP;
            n_count = '0;
        end else begin
            n_state = st;
            n_count = cnt_inc;
        end

        o_res_valid = has_res;
        o_res.status = res;
        if (res == jnl_pkg::ST_INT) begin
            o_res.int_value = n_neg ? n_nmag : $signed({1'b0, n_mag});
        end else begin
            o_res.int_value = '0;
        end
        o_res.num_length = ((res == jnl_pkg::ST_INT) || (res == jnl_pkg::ST_REAL)) ? len : '0;

        if (has_res) begin
            n_mag  = '0;
            n_nmag = '0;
            n_neg  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_mag   <= '0;
            r_nmag  <= '0;
            r_neg   <= 1'b0;
            r_count <= '0;
        end else if (i_take) begin
            r_state <= n_state;
            r_mag   <= n_mag;
            r_nmag  <= n_nmag;
            r_neg   <= n_neg;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

### rtl/json_number_lexer.sv
// JSON number lexer.
// Input channel: one buffer byte per transfer (char_byte, buffer_end) on
// i_in_valid / o_in_ready with payload i_in_data. Output channel: one result
// per buffer (status, int_value, num_length) on o_out_valid / i_out_ready
// with payload o_out_data.
// Each byte is checked and folded into the running value in the cycle of its
// transfer; its result is registered into the main output register, or into
// the skid register while the main one holds a stalled result. While the skid
// register is empty a byte can be taken every cycle, so the sustained rate is
// one byte per cycle, bound by the multiply-by-ten add on the 63-bit magnitude.
// After a result, remaining bytes up to the one flagged as last are taken
// and dropped at the same rate.
// The output has a main register and one skid register. When the receiver
// stalls, one further result can still be stored; o_in_ready drops only
// while the skid register holds a result.
// Reset (synchronous, active low) returns the lexer to its initial state and
// empties both output registers.
`timescale 1ns / 1ps
`default_nettype none

module json_number_lexer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire jnl_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output jnl_pkg::t_out      o_out_data
);

    logic          take;
    logic          res_valid;
    jnl_pkg::t_out res;
    logic          push;

    logic          r_out_valid, r_skid_valid;
    jnl_pkg::t_out r_out, r_skid;

    assign o_in_ready  = !r_skid_valid;
    assign take        = i_in_valid && o_in_ready;
    assign push        = take && res_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    jnl_lexer u_lexer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_item     (i_in_data),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && i_out_ready) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else if (push) begin
                r_out <= res;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (!r_out_valid) begin
            if (push) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end
        end else if (push) begin
            r_skid       <= res;
            r_skid_valid <= 1'b1;
        end
    end

endmodule

`default_nettype wire

### rtl/jnl_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module jnl_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          o_in_ready,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input wire jnl_pkg::t_out o_out_data
);

    // A stalled result stays on the output unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output result changed");

    // Only a successful integer carries a value.
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != jnl_pkg::ST_INT) |->
        o_out_data.int_value == '0)
        else $error("value present on a non-integer result");

    // Failed results carry no length, and a length never exceeds the limit.
    a_len_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_out_data.status == jnl_pkg::ST_SYNTAX) ||
        (o_out_data.status == jnl_pkg::ST_OVER)) |-> o_out_data.num_length == '0)
        else $error("length present on a failed result");

    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.num_length <= jnl_pkg::LEN_W'(jnl_pkg::MAX_LEN))
        else $error("length beyond the limit");

    // Reset empties the output.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("output not empty after reset");

endmodule

bind json_number_lexer jnl_checker u_jnl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_BYTES = 800;
    localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [7:0] TERMS [0:6] = '{
        jnl_pkg::CH_SPACE, jnl_pkg::CH_TAB, jnl_pkg::CH_LF, jnl_pkg::CH_CR,
        jnl_pkg::CH_COMMA, jnl_pkg::CH_RBRACE, jnl_pkg::CH_RBRACKET};
    localparam logic [7:0] TRICKY [0:7] = '{
        jnl_pkg::CH_DOT, jnl_pkg::CH_UPE, jnl_pkg::CH_LOWE, jnl_pkg::CH_PLUS,
        jnl_pkg::CH_MINUS, jnl_pkg::CH_ZERO, jnl_pkg::CH_NINE, jnl_pkg::CH_SPACE};

    typedef enum logic [3:0] {
        LX_START, LX_ZERO, LX_SIGN, LX_INT, LX_DOT,
        LX_FRAC, LX_EXP, LX_ESIGN, LX_EDIG, LX_DISCARD
    } t_lex_state;

    typedef enum int {BUF_NUMBER, BUF_BROKEN, BUF_WIDE_INT, BUF_LONG, BUF_NOISE} t_buf_kind;
    typedef enum int {RX_STEADY, RX_COIN, RX_LONG} t_rx_mode;

    class t_num_check;
        t_lex_state      state;
        logic [62:0]     mag;
        logic            neg;
        logic [6:0]      count;
        jnl_pkg::t_out   awaited_numbers[$];
        int              failures;

        function new();
            failures = 0;
            restart(LX_START);
        endfunction

        function void restart(t_lex_state s);
            state = s;
            mag = '0;
            neg = 1'b0;
            count = '0;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= jnl_pkg::CH_ZERO && c <= jnl_pkg::CH_NINE;
        endfunction

        function bit is_e(logic [7:0] c);
            return c == jnl_pkg::CH_UPE || c == jnl_pkg::CH_LOWE;
        endfunction

        function bit is_term(logic [7:0] c);
            return c == jnl_pkg::CH_SPACE || c == jnl_pkg::CH_TAB ||
                   c == jnl_pkg::CH_LF || c == jnl_pkg::CH_CR ||
                   c == jnl_pkg::CH_COMMA || c == jnl_pkg::CH_RBRACE ||
                   c == jnl_pkg::CH_RBRACKET;
        endfunction

        function void lex_byte(jnl_pkg::t_in b);
            t_lex_state    nxt;
            logic [7:0]    c;
            logic [1:0]    st;
            bit            done;
            logic [6:0]    len;
            logic [63:0]   d;
            logic [63:0]   val;
            jnl_pkg::t_out r;
            c = b.char_byte;
            if (state == LX_DISCARD) begin
                if (b.buffer_end)
                    restart(LX_START);
                return;
            end
            nxt = state;
            done = 1'b0;
            len = '0;
            st = jnl_pkg::ST_SYNTAX;
            case (state)
                LX_START, LX_SIGN: begin
                    if (c > jnl_pkg::CH_ZERO && c <= jnl_pkg::CH_NINE) begin
                        mag = 63'(c - jnl_pkg::CH_ZERO);
                        nxt = LX_INT;
                    end else if (c == jnl_pkg::CH_ZERO) begin
                        nxt = LX_ZERO;
                    end else if (c == jnl_pkg::CH_MINUS && state == LX_START) begin
                        neg = 1'b1;
                        nxt = LX_SIGN;
                    end else begin
                        done = 1'b1;
                    end
                end
                LX_ZERO, LX_INT: begin
                    if (is_digit(c) && state == LX_INT) begin
                        d = 64'(c - jnl_pkg::CH_ZERO);
                        if ({1'b0, mag} > (MAG_MAX - d) / 64'd10) begin
                            done = 1'b1;
                            st = jnl_pkg::ST_OVER;
                        end else begin
                            mag = 63'({1'b0, mag} * 64'd10 + d);
                        end
                    end else if (c == jnl_pkg::CH_DOT) begin
                        nxt = LX_DOT;
                    end else if (is_e(c)) begin
                        nxt = LX_EXP;
                    end else if (is_term(c)) begin
                        done = 1'b1;
                        st = jnl_pkg::ST_INT;
                        len = count;
                    end else begin
                        done = 1'b1;
                    end
                end
                LX_DOT, LX_ESIGN: begin
                    if (is_digit(c))
                        nxt = (state == LX_DOT) ? LX_FRAC : LX_EDIG;
                    else
                        done = 1'b1;
                end
                LX_FRAC, LX_EDIG: begin
                    if (is_digit(c)) begin
                        nxt = state;
                    end else if (is_e(c) && state == LX_FRAC) begin
                        nxt = LX_EXP;
                    end else if (is_term(c)) begin
                        done = 1'b1;
                        st = jnl_pkg::ST_REAL;
                        len = count;
                    end else begin
                        done = 1'b1;
                    end
                end
                LX_EXP: begin
                    if (c == jnl_pkg::CH_PLUS || c == jnl_pkg::CH_MINUS)
                        nxt = LX_ESIGN;
                    else if (is_digit(c))
                        nxt = LX_EDIG;
                    else
                        done = 1'b1;
                end
                default: begin
                    done = 1'b1;
                end
            endcase
            if (!done) begin
                count = count + 7'd1;
                if (b.buffer_end) begin
                    len = count;
                    if (nxt == LX_ZERO || nxt == LX_INT)
                        st = jnl_pkg::ST_INT;
                    else if (nxt == LX_FRAC || nxt == LX_EDIG)
                        st = jnl_pkg::ST_REAL;
                    else
                        st = jnl_pkg::ST_SYNTAX;
                end else if (count >= jnl_pkg::MAX_LEN) begin
                    st = jnl_pkg::ST_OVER;
                end else begin
                    state = nxt;
                    return;
                end
            end
            val = neg ? 64'd0 - {1'b0, mag} : {1'b0, mag};
            r.status = st;
            r.int_value = (st == jnl_pkg::ST_INT) ? val : '0;
            r.num_length = (st == jnl_pkg::ST_INT || st == jnl_pkg::ST_REAL) ? len : '0;
            awaited_numbers.push_back(r);
            restart(b.buffer_end ? LX_START : LX_DISCARD);
        endfunction

        function void check_result(jnl_pkg::t_out got);
            jnl_pkg::t_out exp_r;
            if (awaited_numbers.size() == 0) begin
                if (failures < 10)
                    $display("unexpected result: status %0d value %0d length %0d",
                             got.status, $signed(got.int_value), got.num_length);
                failures++;
                return;
            end
            exp_r = awaited_numbers.pop_front();
            if (got.status !== exp_r.status || got.int_value !== exp_r.int_value ||
                got.num_length !== exp_r.num_length) begin
                if (failures < 10) begin
                    $write("mismatch: expected status %0d value %0d length %0d, ",
                           exp_r.status, $signed(exp_r.int_value), exp_r.num_length);
                    $display("got status %0d value %0d length %0d",
                             got.status, $signed(got.int_value), got.num_length);
                end
                failures++;
            end
        endfunction

        function bit drained();
            return awaited_numbers.size() == 0;
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_ready;
    jnl_pkg::t_in  i_in_data;
    logic          o_out_valid;
    logic          i_out_ready;
    jnl_pkg::t_out o_out_data;

    t_num_check book = new();
    logic [7:0] text[$];
    int         burst_left = 0;
    int         bytes_sent = 0;
    int         idle_cycles = 0;
    int         rx_run = 0;
    t_rx_mode   rx_mode = RX_STEADY;

    json_number_lexer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                book.lex_byte(i_in_data);
            if (o_out_valid && i_out_ready)
                book.check_result(o_out_data);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (rx_run == 0) begin
            if ($urandom_range(0, 15) == 0)
                rx_mode = t_rx_mode'($urandom_range(0, 2));
            case (rx_mode)
                RX_STEADY: begin
                    i_out_ready <= 1'b1;
                    rx_run = $urandom_range(1, 16);
                end
                RX_COIN: begin
                    i_out_ready <= 1'($urandom_range(0, 1));
                    rx_run = 1;
                end
                default: begin
                    i_out_ready <= !i_out_ready;
                    rx_run = i_out_ready ? $urandom_range(5, 30) : $urandom_range(1, 4);
                end
            endcase
        end else begin
            rx_run--;
        end
    end

    task automatic send_byte(input jnl_pkg::t_in b);
        i_in_valid <= 1'b1;
        i_in_data <= b;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        bytes_sent++;
    endtask

    task automatic send_buffer();
        jnl_pkg::t_in b;
        for (int i = 0; i < text.size(); i++) begin
            if (burst_left == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                         : $urandom_range(1, 20);
            end
            burst_left--;
            b.char_byte = text[i];
            b.buffer_end = (i == text.size() - 1);
            send_byte(b);
        end
        text.delete();
    endtask

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
    endfunction

    task automatic send_text(string s);
        push_str(s);
        send_buffer();
    endtask

    function automatic logic [7:0] any_digit();
        return jnl_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] lead_digit();
        return jnl_pkg::CH_ZERO + 8'($urandom_range(1, 9));
    endfunction

    function automatic void push_number();
        int n;
        if ($urandom_range(0, 2) == 0)
            text.push_back(jnl_pkg::CH_MINUS);
        if ($urandom_range(0, 5) == 0) begin
            text.push_back(jnl_pkg::CH_ZERO);
        end else begin
            text.push_back(lead_digit());
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 17) : $urandom_range(0, 5);
            repeat (n) text.push_back(any_digit());
        end
        if ($urandom_range(0, 2) == 0) begin
            text.push_back(jnl_pkg::CH_DOT);
            repeat ($urandom_range(1, 4)) text.push_back(any_digit());
        end
        if ($urandom_range(0, 3) == 0) begin
            text.push_back($urandom_range(0, 1) ? jnl_pkg::CH_UPE : jnl_pkg::CH_LOWE);
            case ($urandom_range(0, 2))
                0: text.push_back(jnl_pkg::CH_PLUS);
                1: text.push_back(jnl_pkg::CH_MINUS);
                default: ;
            endcase
            repeat ($urandom_range(1, 3)) text.push_back(any_digit());
        end
    endfunction

    // Magnitudes around the signed 64-bit limit, on both sides of it.
    function automatic void push_wide_int();
        if ($urandom_range(0, 1) == 0)
            text.push_back(jnl_pkg::CH_MINUS);
        case ($urandom_range(0, 3))
            0: begin
                push_str("922337203685477580");
                text.push_back(jnl_pkg::CH_ZERO + 8'($urandom_range(6, 9)));
            end
            1: push_str("9223372036854775807");
            2: begin
                text.push_back(lead_digit());
                repeat (18) text.push_back(any_digit());
            end
            default: begin
                text.push_back(lead_digit());
                repeat (19) text.push_back(any_digit());
            end
        endcase
    endfunction

    function automatic void push_long();
        int target;
        target = $urandom_range(jnl_pkg::MAX_LEN - 2, jnl_pkg::MAX_LEN + 2);
        if ($urandom_range(0, 1) == 0)
            text.push_back(jnl_pkg::CH_MINUS);
        push_str($urandom_range(0, 1) ? "0." : "1e");
        while (text.size() < target)
            text.push_back(any_digit());
    endfunction

    function automatic void push_broken();
        int idx;
        push_number();
        if ($urandom_range(0, 1) == 0) begin
            idx = $urandom_range(0, text.size() - 1);
            text[idx] = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                             : TRICKY[$urandom_range(0, 7)];
        end else begin
            case ($urandom_range(0, 3))
                0: text.push_back(jnl_pkg::CH_DOT);
                1: text.push_back(jnl_pkg::CH_LOWE);
                2: begin
                    text.push_back(jnl_pkg::CH_UPE);
                    text.push_back(jnl_pkg::CH_PLUS);
                end
                default: text.push_back(jnl_pkg::CH_MINUS);
            endcase
        end
    endfunction

    function automatic void push_ending();
        if ($urandom_range(0, 2) != 0) begin
            text.push_back(TERMS[$urandom_range(0, 6)]);
            repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    initial begin
        t_buf_kind kind;
        int        pick;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_out_ready <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_text("0");
        send_text("-");
        text.push_back(8'h00);
        send_buffer();
        text.push_back(8'hFF);
        send_buffer();
        send_text("12 ");
        send_text("-0.5e+9}");
        send_text("3E-1]");
        send_text("01\t");
        send_text("1.e");
        send_text("2e");
        send_text("7,\r\n");

        while (bytes_sent < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                kind = BUF_NUMBER;
            else if (pick < 70)
                kind = BUF_BROKEN;
            else if (pick < 82)
                kind = BUF_WIDE_INT;
            else if (pick < 86)
                kind = BUF_LONG;
            else
                kind = BUF_NOISE;
            case (kind)
                BUF_NUMBER:   push_number();
                BUF_BROKEN:   push_broken();
                BUF_WIDE_INT: push_wide_int();
                BUF_LONG:     push_long();
                default: begin
                    repeat ($urandom_range(1, 4))
                        text.push_back(8'($urandom_range(0, 255)));
                end
            endcase
            if (kind != BUF_NOISE)
                push_ending();
            send_buffer();
        end
        i_in_valid <= 1'b0;

        while (!book.drained())
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (book.failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
